[src/srsp_pkg.sv]
// shared types, constants and header layout tables for the song record parser
package srsp_pkg;

  localparam int HDR_ITEMS = 22;
  localparam int QDEPTH = 4;
  localparam int QAW = 2;

  localparam logic [2:0] KIND_HDR  = 3'd0;
  localparam logic [2:0] KIND_NOTE = 3'd1;
  localparam logic [2:0] KIND_TEND = 3'd2;
  localparam logic [2:0] KIND_DONE = 3'd3;
  localparam logic [2:0] KIND_ERR  = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic [2:0]         rec_kind;
    logic [4:0]         header_index;
    logic signed [31:0] header_value;
    logic signed [31:0] tick_number;
    logic signed [7:0]  instrument;
    logic signed [7:0]  note_key;
    logic signed [7:0]  velocity;
    logic signed [7:0]  panning;
    logic signed [15:0] fine_pitch;
    logic [15:0]        notes_in_tick;
  } out_req_t;

  // byte as registered by the front stage
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } qentry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // byte width of each header item, zero for a length-prefixed string
  function automatic logic [2:0] hdr_width(input logic [4:0] step);
    logic [2:0] w;
    case (step)
      5'd0, 5'd3, 5'd4, 5'd9, 5'd21:             w = 3'd2;
      5'd1, 5'd2, 5'd10, 5'd11, 5'd12, 5'd19, 5'd20: w = 3'd1;
      5'd13, 5'd14, 5'd15, 5'd16, 5'd17:         w = 3'd4;
      default:                                   w = 3'd0;
    endcase
    return w;
  endfunction

  // numeric field index of each header item
  function automatic logic [4:0] hdr_index(input logic [4:0] step);
    logic [4:0] idx;
    case (step)
      5'd0, 5'd1, 5'd2, 5'd3, 5'd4: idx = step;
      5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17:
        idx = step - 5'd4;
      5'd19, 5'd20, 5'd21: idx = step - 5'd5;
      default: idx = 5'd0;
    endcase
    return idx;
  endfunction

endpackage

[src/srsp_front.sv]
// input stage: takes byte requests and hands registered entries to the queue
module srsp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  srsp_pkg::in_req_t   in_data,
  input  srsp_pkg::qstat_t    q_stat,
  output logic                push,
  output srsp_pkg::qentry_t   push_data
);

  logic              valid_r, valid_nxt;
  srsp_pkg::qentry_t ent_r;
  logic              accept;

  assign in_stall  = valid_r && q_stat.full;
  assign accept    = in_valid && !in_stall;
  assign push      = valid_r && !q_stat.full;
  assign push_data = ent_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (accept) begin
      ent_r.data <= in_data.in_byte;
      ent_r.last <= in_data.last_byte;
    end
  end

endmodule

[src/srsp_queue.sv]
// short byte queue between front and back
module srsp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  srsp_pkg::qentry_t push_data,
  input  logic              pop,
  output srsp_pkg::qstat_t  q_stat,
  output srsp_pkg::qentry_t pop_data
);

  srsp_pkg::qentry_t    mem_r [srsp_pkg::QDEPTH];
  logic [srsp_pkg::QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [srsp_pkg::QAW:0]   count_r;
  logic                     do_push, do_pop;

  assign q_stat.full  = (count_r == (srsp_pkg::QAW+1)'(srsp_pkg::QDEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_data     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[src/srsp_back.sv]
// parser state machine and output register
module srsp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  srsp_pkg::qstat_t   q_stat,
  input  srsp_pkg::qentry_t  pop_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output srsp_pkg::out_req_t out_data
);

  typedef enum logic [2:0] {
    PH_HDR, PH_SKIP, PH_TICK, PH_LAYER, PH_NOTE, PH_DONE, PH_ERR
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [4:0]         step_r, step_nxt;
  logic [2:0]         bif_r, bif_nxt;
  logic [31:0]        asm_r, asm_nxt;
  logic [30:0]        skip_r, skip_nxt;
  logic [31:0]        tick_r, tick_nxt;
  logic [15:0]        cnt_r, cnt_nxt;
  logic [31:0]        nb_r, nb_nxt;
  logic               out_valid_r, out_valid_nxt;
  srsp_pkg::out_req_t out_data_r, emit_data;
  logic               emit;

  logic [7:0]  b;
  logic [2:0]  wraw, w;
  logic [2:0]  bif_inc;
  logic [31:0] asm_or;
  logic [31:0] v16;

  assign pop       = !q_stat.empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    b       = pop_data.data;
    wraw    = srsp_pkg::hdr_width(step_r);
    w       = (wraw == 3'd0) ? 3'd4 : wraw;
    bif_inc = bif_r + 3'd1;
    asm_or  = asm_r | ({24'd0, b} << {bif_r[1:0], 3'b000});
    v16     = {{16{b[7]}}, b, asm_r[7:0]};

    phase_nxt = phase_r;
    step_nxt  = step_r;
    bif_nxt   = bif_r;
    asm_nxt   = asm_r;
    skip_nxt  = skip_r;
    tick_nxt  = tick_r;
    cnt_nxt   = cnt_r;
    nb_nxt    = nb_r;
    emit      = 1'b0;
    emit_data = '0;

    if (pop) begin
      if (phase_r == PH_DONE || phase_r == PH_ERR) begin
        if (pop_data.last) begin
          phase_nxt = PH_HDR;
          step_nxt  = '0;
          bif_nxt   = '0;
          asm_nxt   = '0;
          skip_nxt  = '0;
          tick_nxt  = '1;
          cnt_nxt   = '0;
          nb_nxt    = '0;
        end
      end else if (pop_data.last) begin
        emit               = 1'b1;
        emit_data.rec_kind = srsp_pkg::KIND_ERR;
        phase_nxt = PH_HDR;
        step_nxt  = '0;
        bif_nxt   = '0;
        asm_nxt   = '0;
        skip_nxt  = '0;
        tick_nxt  = '1;
        cnt_nxt   = '0;
        nb_nxt    = '0;
      end else begin
        case (phase_r)
          PH_HDR: begin
            asm_nxt = asm_or;
            bif_nxt = bif_inc;
            if (bif_inc >= w) begin
              bif_nxt = '0;
              asm_nxt = '0;
              if (wraw == 3'd0) begin
                if (asm_or[31]) begin
                  phase_nxt          = PH_ERR;
                  emit               = 1'b1;
                  emit_data.rec_kind = srsp_pkg::KIND_ERR;
                end else if (asm_or == '0) begin
                  step_nxt  = (step_r == 5'(srsp_pkg::HDR_ITEMS - 1)) ? '0 : step_r + 5'd1;
                  phase_nxt = (step_r == 5'(srsp_pkg::HDR_ITEMS - 1)) ? PH_TICK : PH_HDR;
                end else begin
                  skip_nxt  = asm_or[30:0];
                  phase_nxt = PH_SKIP;
                end
              end else begin
                emit                   = 1'b1;
                emit_data.rec_kind     = srsp_pkg::KIND_HDR;
                emit_data.header_index = srsp_pkg::hdr_index(step_r);
                case (w)
                  3'd1:    emit_data.header_value = {{24{asm_or[7]}}, asm_or[7:0]};
                  3'd2:    emit_data.header_value = {{16{asm_or[15]}}, asm_or[15:0]};
                  default: emit_data.header_value = asm_or;
                endcase
                step_nxt  = (step_r == 5'(srsp_pkg::HDR_ITEMS - 1)) ? '0 : step_r + 5'd1;
                phase_nxt = (step_r == 5'(srsp_pkg::HDR_ITEMS - 1)) ? PH_TICK : PH_HDR;
              end
            end
          end
          PH_SKIP: begin
            skip_nxt = (skip_r != '0) ? skip_r - 31'd1 : skip_r;
            if (skip_r <= 31'd1) begin
              bif_nxt   = '0;
              asm_nxt   = '0;
              step_nxt  = (step_r == 5'(srsp_pkg::HDR_ITEMS - 1)) ? '0 : step_r + 5'd1;
              phase_nxt = (step_r == 5'(srsp_pkg::HDR_ITEMS - 1)) ? PH_TICK : PH_HDR;
            end
          end
          PH_TICK: begin
            if (bif_r[0] == 1'b0) begin
              asm_nxt = {24'd0, b};
              bif_nxt = 3'd1;
            end else begin
              asm_nxt = '0;
              bif_nxt = '0;
              if (v16 == '0) begin
                phase_nxt          = PH_DONE;
                emit               = 1'b1;
                emit_data.rec_kind = srsp_pkg::KIND_DONE;
              end else begin
                tick_nxt  = tick_r + v16;
                cnt_nxt   = '0;
                phase_nxt = PH_LAYER;
              end
            end
          end
          PH_LAYER: begin
            if (bif_r[0] == 1'b0) begin
              asm_nxt = {24'd0, b};
              bif_nxt = 3'd1;
            end else begin
              asm_nxt = '0;
              bif_nxt = '0;
              if (v16[15:0] == '0) begin
                emit                    = 1'b1;
                emit_data.rec_kind      = srsp_pkg::KIND_TEND;
                emit_data.tick_number   = tick_r;
                emit_data.notes_in_tick = cnt_r;
                cnt_nxt   = '0;
                phase_nxt = PH_TICK;
              end else begin
                nb_nxt    = '0;
                phase_nxt = PH_NOTE;
              end
            end
          end
          PH_NOTE: begin
            bif_nxt = bif_inc;
            if (bif_r < 3'd4) begin
              nb_nxt = nb_r | ({24'd0, b} << {bif_r[1:0], 3'b000});
            end else if (bif_r == 3'd4) begin
              asm_nxt = {24'd0, b};
            end else begin
              emit                  = 1'b1;
              emit_data.rec_kind    = srsp_pkg::KIND_NOTE;
              emit_data.tick_number = tick_r;
              emit_data.instrument  = nb_r[7:0];
              emit_data.note_key    = nb_r[15:8];
              emit_data.velocity    = nb_r[23:16];
              emit_data.panning     = nb_r[31:24];
              emit_data.fine_pitch  = {b, asm_r[7:0]};
              cnt_nxt   = (cnt_r != 16'hFFFF) ? cnt_r + 16'd1 : cnt_r;
              bif_nxt   = '0;
              asm_nxt   = '0;
              nb_nxt    = '0;
              phase_nxt = PH_LAYER;
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR;
      step_r      <= '0;
      bif_r       <= '0;
      asm_r       <= '0;
      skip_r      <= '0;
      tick_r      <= '1;
      cnt_r       <= '0;
      nb_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      step_r      <= step_nxt;
      bif_r       <= bif_nxt;
      asm_r       <= asm_nxt;
      skip_r      <= skip_nxt;
      tick_r      <= tick_nxt;
      cnt_r       <= cnt_nxt;
      nb_r        <= nb_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (emit) begin
      out_data_r <= emit_data;
    end
  end

endmodule

[src/song_record_stream_parser.sv]
// top level of the song record stream parser
// usage:
//   in_valid/in_stall/in_data carry one file byte per request, with
//   last_byte set on the final byte of the file.
//   out_valid/out_stall/out_data carry parsed records: header fields,
//   notes, tick ends, parse done and error records.
//   a byte is registered in the front stage, passes a four-entry queue and
//   is parsed by the back state machine, one byte per cycle unless the queue
//   is empty or a pending record is stalled; a record it causes is then
//   held in the output register. sustained throughput is one byte per
//   cycle while out_stall is low, set by the parser update in the back stage.
//   when out_stall is held, the output register keeps its record and the
//   queue fills; in_stall rises once the queue and front register are full.
//   reset (rst_n low, synchronous) empties the queue, drops any pending
//   record and restarts the parser at the header with the tick at -1.
//   after parse done or an error, bytes are dropped until the final byte,
//   which rearms the parser without a record.
module song_record_stream_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  srsp_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output srsp_pkg::out_req_t out_data
);

  srsp_pkg::qstat_t  q_stat;
  srsp_pkg::qentry_t push_data, pop_data;
  logic              push, pop;

  srsp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  srsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_stat    (q_stat),
    .pop_data  (pop_data)
  );

  srsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
